// ===== rtl/wsenc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wsenc_pkg
// Types, constants and helpers shared by the WebSocket client frame encoder.
// ----------------------------------------------------------------------------
package wsenc_pkg;

  localparam int unsigned LEN_W  = 63;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned OPC_W  = 4;
  localparam int unsigned IDX_W  = 4;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  localparam logic [BYTE_W-1:0] FIN_BIT    = 8'h80;
  localparam logic [BYTE_W-1:0] MASK_BIT   = 8'h80;
  localparam logic [BYTE_W-1:0] LEN16_CODE = 8'hFE;
  localparam logic [BYTE_W-1:0] LEN64_CODE = 8'hFF;
  localparam logic [LEN_W-1:0]  LEN_INLINE_LIMIT = LEN_W'(126);
  localparam logic [LEN_W-1:0]  LEN16_MAX        = LEN_W'(16'hFFFF);

  typedef enum logic {
    KIND_HEADER,
    KIND_DATA
  } entry_kind_t;

  typedef enum logic [1:0] {
    LEN_SHORT,
    LEN_MID,
    LEN_LONG
  } len_class_t;

  // One queued job: a whole header burst or a single masked payload byte.
  typedef struct packed {
    entry_kind_t        kind;
    logic [OPC_W-1:0]   opcode;
    len_class_t         len_class;
    logic [LEN_W-1:0]   length;
    logic [KEY_W-1:0]   key;
    logic [BYTE_W-1:0]  data;
    logic               last;
  } entry_t;

  function automatic logic [BYTE_W-1:0] key_byte(input logic [KEY_W-1:0] key,
                                                 input logic [1:0] pos);
    logic [BYTE_W-1:0] b;
    case (pos)
      2'd0:    b = key[31:24];
      2'd1:    b = key[23:16];
      2'd2:    b = key[15:8];
      default: b = key[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [IDX_W-1:0] ext_count(input len_class_t c);
    logic [IDX_W-1:0] n;
    case (c)
      LEN_MID:  n = IDX_W'(2);
      LEN_LONG: n = IDX_W'(8);
      default:  n = IDX_W'(0);
    endcase
    return n;
  endfunction

  function automatic logic [IDX_W-1:0] header_last_idx(input len_class_t c);
    return ext_count(c) + IDX_W'(5);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/wsenc_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wsenc_in_if
// Input channel of the frame encoder: start items and payload bytes.
// ----------------------------------------------------------------------------
interface wsenc_in_if
  import wsenc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [OPC_W-1:0]  opcode;
  logic [LEN_W-1:0]  payload_length;
  logic [KEY_W-1:0]  mask_key;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, operation, opcode, payload_length, mask_key, data_byte,
                  input ready);
  modport sink (input valid, operation, opcode, payload_length, mask_key, data_byte,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/wsenc_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wsenc_out_if
// Output channel of the frame encoder: one wire byte per beat.
// ----------------------------------------------------------------------------
interface wsenc_out_if
  import wsenc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  modport source (output valid, out_byte, last, input ready);
  modport sink (input valid, out_byte, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/websocket_client_frame_encoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_client_frame_encoder
// Builds masked client-to-server WebSocket frames as a stream of bytes.
// ----------------------------------------------------------------------------
// Channel   Direction  Beat contents
// in_chan   sink       operation, opcode, payload_length, mask_key, data_byte
// out_chan  source     out_byte, last
//
// A payload byte is accepted every cycle while the job queue is not full; its
// masked byte passes through the job queue and then the registered output byte.
// A start item yields a header burst of 6, 8 or 14 bytes, one per cycle while
// the output does not stall, paced by the byte counter of the back part.
// Input stalls only while the job queue is full; output stalls hold the
// registered output byte. Reset clears the frame state and the queue.
// ----------------------------------------------------------------------------
module websocket_client_frame_encoder
  import wsenc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  wsenc_in_if.sink    in_chan,
  wsenc_out_if.source out_chan
);

  logic   q_push, q_full, q_pop, q_head_valid;
  entry_t q_push_entry, q_head_entry;

  wsenc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_push_entry)
  );

  wsenc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_entry (q_head_entry)
  );

  wsenc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_entry (q_head_entry),
    .pop        (q_pop),
    .out_chan   (out_chan)
  );

endmodule
`default_nettype wire

// ===== rtl/wsenc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wsenc_front
// Accepts items, tracks the open frame, masks payload bytes and queues jobs.
// ----------------------------------------------------------------------------
module wsenc_front
  import wsenc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  wsenc_in_if.sink    in_chan,
  input  wire logic   q_full,
  output logic        q_push,
  output entry_t      q_entry
);

  logic             frame_open_r, frame_open_nxt;
  logic [LEN_W-1:0] remain_r, remain_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [1:0]       pos_r, pos_nxt;

  logic             accept;
  logic             is_start;
  logic [LEN_W-1:0] remain_dec;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && !q_full;
  assign is_start      = (in_chan.operation == OP_START);
  assign remain_dec    = remain_r - LEN_W'(1);
  assign q_push        = accept && (is_start || frame_open_r);

  always_comb begin
    frame_open_nxt = frame_open_r;
    remain_nxt     = remain_r;
    key_nxt        = key_r;
    pos_nxt        = pos_r;

    q_entry.kind      = KIND_HEADER;
    q_entry.opcode    = in_chan.opcode;
    q_entry.length    = in_chan.payload_length;
    q_entry.key       = in_chan.mask_key;
    q_entry.data      = in_chan.data_byte ^ key_byte(key_r, pos_r);
    q_entry.last      = (in_chan.payload_length == '0);
    if (in_chan.payload_length < LEN_INLINE_LIMIT) begin
      q_entry.len_class = LEN_SHORT;
    end else if (in_chan.payload_length <= LEN16_MAX) begin
      q_entry.len_class = LEN_MID;
    end else begin
      q_entry.len_class = LEN_LONG;
    end

    if (is_start) begin
      if (accept) begin
        key_nxt        = in_chan.mask_key;
        pos_nxt        = 2'd0;
        remain_nxt     = in_chan.payload_length;
        frame_open_nxt = (in_chan.payload_length != '0);
      end
    end else begin
      q_entry.kind = KIND_DATA;
      q_entry.last = (remain_dec == '0);
      if (accept && frame_open_r) begin
        remain_nxt     = remain_dec;
        pos_nxt        = pos_r + 2'd1;
        frame_open_nxt = (remain_dec != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      remain_r     <= '0;
      key_r        <= '0;
      pos_r        <= 2'd0;
    end else begin
      frame_open_r <= frame_open_nxt;
      remain_r     <= remain_nxt;
      key_r        <= key_nxt;
      pos_r        <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/wsenc_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wsenc_queue
// Short first-in first-out queue of jobs between the front and back parts.
// ----------------------------------------------------------------------------
module wsenc_queue
  import wsenc_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_entry,
  output logic        full,
  input  wire logic   pop,
  output logic        head_valid,
  output entry_t      head_entry
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= advance(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= advance(rd_ptr_r);
      end
      if (push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/wsenc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wsenc_back
// Serialises queued jobs into wire bytes through a registered output stage.
// ----------------------------------------------------------------------------
module wsenc_back
  import wsenc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   head_valid,
  input  wire entry_t head_entry,
  output logic        pop,
  wsenc_out_if.source out_chan
);

  logic [IDX_W-1:0]  idx_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;

  logic              take, emit, done;
  logic [BYTE_W-1:0] byte_val;
  logic              last_val;
  logic [IDX_W-1:0]  ext_n, last_idx, ext_pos, key_pos;
  logic [63:0]       ext_word;

  assign take     = !out_valid_r || out_chan.ready;
  assign emit     = head_valid && take;
  assign ext_n    = ext_count(head_entry.len_class);
  assign last_idx = header_last_idx(head_entry.len_class);
  assign ext_pos  = ext_n + IDX_W'(1) - idx_r;
  assign key_pos  = idx_r - IDX_W'(2) - ext_n;
  assign ext_word = {1'b0, head_entry.length};
  assign done     = (head_entry.kind == KIND_DATA) || (idx_r == last_idx);
  assign pop      = emit && done;

  always_comb begin
    byte_val = head_entry.data;
    last_val = head_entry.last;
    if (head_entry.kind == KIND_HEADER) begin
      last_val = head_entry.last && (idx_r == last_idx);
      if (idx_r == IDX_W'(0)) begin
        byte_val = FIN_BIT | {4'h0, head_entry.opcode};
      end else if (idx_r == IDX_W'(1)) begin
        case (head_entry.len_class)
          LEN_MID:  byte_val = LEN16_CODE;
          LEN_LONG: byte_val = LEN64_CODE;
          default:  byte_val = MASK_BIT | {1'b0, head_entry.length[6:0]};
        endcase
      end else if (idx_r < ext_n + IDX_W'(2)) begin
        byte_val = ext_word[ext_pos[2:0]*8 +: 8];
      end else begin
        byte_val = key_byte(head_entry.key, key_pos[1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
      idx_r       <= done ? '0 : idx_r + IDX_W'(1);
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= byte_val;
      out_last_r <= last_val;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.out_byte = out_byte_r;
  assign out_chan.last     = out_last_r;

endmodule
`default_nettype wire
